### hdl/kpu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpu_pkg: shared definitions for the permutation unranking unit
// Widths, the factorial table and the sequencer state type.
// ----------------------------------------------------------------------------
package kpu_pkg;

    // Longest permutation that the unit handles.
    localparam int MAX_LENGTH = 16;

    // Field widths.
    localparam int LEN_W  = 5;
    localparam int RANK_W = 45;
    localparam int SYM_W  = 5;
    localparam int IDX_W  = $clog2(MAX_LENGTH);

    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [RANK_W-1:0] rank_t;
    typedef logic [SYM_W-1:0]  sym_t;
    typedef logic [IDX_W-1:0]  idx_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        KPU_IDLE,
        KPU_CHECK,
        KPU_DIGIT
    } kpu_state_t;

    // Factorials of 0 through 16; other arguments return zero.
    function automatic rank_t fact(input len_t n);
        rank_t f;
        case (n)
            5'd0:    f = 45'd1;
            5'd1:    f = 45'd1;
            5'd2:    f = 45'd2;
            5'd3:    f = 45'd6;
            5'd4:    f = 45'd24;
            5'd5:    f = 45'd120;
            5'd6:    f = 45'd720;
            5'd7:    f = 45'd5040;
            5'd8:    f = 45'd40320;
            5'd9:    f = 45'd362880;
            5'd10:   f = 45'd3628800;
            5'd11:   f = 45'd39916800;
            5'd12:   f = 45'd479001600;
            5'd13:   f = 45'd6227020800;
            5'd14:   f = 45'd87178291200;
            5'd15:   f = 45'd1307674368000;
            5'd16:   f = 45'd20922789888000;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

### hdl/kth_permutation_unrank_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kth_permutation_unrank_unit: lexicographic permutation unranking
// Emits the rank-th permutation of positions 1..length, one position per
// result transaction, using the factorial number system.
// ----------------------------------------------------------------------------
// A request carries a length (1..16) and a zero-based rank. The unit returns
// length result transactions, each one original position, with last set on
// the final one. A length of zero, above 16, or a rank not below length!
// returns a single transaction with symbol_position 0, last and rank_error
// set. One compare-subtract unit steps the remaining rank down by the
// current factorial once per cycle until the digit of the result is found.
// A request is accepted in the idle state and checked in the check state
// before its digits are extracted; an error result and each position wait
// while the result side stalls. The symbol list shrinks by a shift made in
// the same cycle as each result is loaded. The unit takes a new request
// while the final result of the previous one still waits in the output
// register.
module kth_permutation_unrank_unit
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  kpu_pkg::len_t        length,
    input  kpu_pkg::rank_t       rank,
    output logic                 res_valid,
    input  logic                 res_ready,
    output kpu_pkg::sym_t        symbol_position,
    output logic                 last,
    output logic                 rank_error
);

    kpu_pkg::kpu_state_t state_reg, state_next;

    kpu_pkg::len_t  length_reg, length_next;
    kpu_pkg::rank_t rank_reg, rank_next;
    kpu_pkg::len_t  count_reg, count_next;
    kpu_pkg::idx_t  digit_reg, digit_next;
    kpu_pkg::sym_t  symbols_reg [kpu_pkg::MAX_LENGTH];
    kpu_pkg::sym_t  symbols_next [kpu_pkg::MAX_LENGTH];

    logic           out_valid_reg, out_valid_next;
    kpu_pkg::sym_t  out_sym_reg, out_sym_next;
    logic           out_last_reg, out_last_next;
    logic           out_err_reg, out_err_next;

    kpu_pkg::rank_t f_sel;
    logic           rank_ge;
    logic           bad_req;
    logic           step;
    logic           slot_free;

    // Shared compare unit: request check against length!, digit steps
    // against (count-1)!.
    always_comb
    begin
        if (state_reg == kpu_pkg::KPU_CHECK)
        begin
            f_sel = kpu_pkg::fact(length_reg);
        end
        else
        begin
            f_sel = kpu_pkg::fact(count_reg - 5'd1);
        end
        rank_ge = (rank_reg >= f_sel);
    end

    assign bad_req   = (length_reg == '0)
                     || (length_reg > kpu_pkg::LEN_W'(kpu_pkg::MAX_LENGTH))
                     || rank_ge;
    assign step      = rank_ge && ({1'b0, digit_reg} < (count_reg - 5'd1));
    assign slot_free = !out_valid_reg || res_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kpu_pkg::KPU_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = kpu_pkg::KPU_CHECK;
                end
            end
            kpu_pkg::KPU_CHECK:
            begin
                if (!bad_req)
                begin
                    state_next = kpu_pkg::KPU_DIGIT;
                end
                else if (slot_free)
                begin
                    state_next = kpu_pkg::KPU_IDLE;
                end
            end
            kpu_pkg::KPU_DIGIT:
            begin
                if (!step && slot_free && (count_reg == 5'd1))
                begin
                    state_next = kpu_pkg::KPU_IDLE;
                end
            end
            default:
            begin
                state_next = kpu_pkg::KPU_IDLE;
            end
        endcase
    end

    // Datapath and output register updates.
    always_comb
    begin
        length_next    = length_reg;
        rank_next      = rank_reg;
        count_next     = count_reg;
        digit_next     = digit_reg;
        symbols_next   = symbols_reg;
        out_sym_next   = out_sym_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        out_valid_next = out_valid_reg && !res_ready;

        unique case (state_reg)
            kpu_pkg::KPU_IDLE:
            begin
                if (req_valid)
                begin
                    length_next = length;
                    rank_next   = rank;
                end
            end
            kpu_pkg::KPU_CHECK:
            begin
                if (!bad_req)
                begin
                    for (int i = 0; i < kpu_pkg::MAX_LENGTH; i++)
                    begin
                        symbols_next[i] = kpu_pkg::SYM_W'(i + 1);
                    end
                    count_next = length_reg;
                    digit_next = '0;
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_sym_next   = '0;
                    out_last_next  = 1'b1;
                    out_err_next   = 1'b1;
                end
            end
            kpu_pkg::KPU_DIGIT:
            begin
                if (step)
                begin
                    rank_next  = rank_reg - f_sel;
                    digit_next = digit_reg + 1'b1;
                end
                else if (slot_free)
                begin
                    // Emit the selected symbol and close the gap behind it.
                    out_valid_next = 1'b1;
                    out_sym_next   = symbols_reg[digit_reg];
                    out_last_next  = (count_reg == 5'd1);
                    out_err_next   = 1'b0;
                    for (int j = 0; j < kpu_pkg::MAX_LENGTH - 1; j++)
                    begin
                        if (kpu_pkg::IDX_W'(j) >= digit_reg)
                        begin
                            symbols_next[j] = symbols_reg[j + 1];
                        end
                    end
                    count_next = count_reg - 5'd1;
                    digit_next = '0;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !res_ready;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kpu_pkg::KPU_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            digit_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            digit_reg     <= digit_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        length_reg   <= length_next;
        rank_reg     <= rank_next;
        symbols_reg  <= symbols_next;
        out_sym_reg  <= out_sym_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    assign req_ready       = (state_reg == kpu_pkg::KPU_IDLE);
    assign res_valid       = out_valid_reg;
    assign symbol_position = out_sym_reg;
    assign last            = out_last_reg;
    assign rank_error      = out_err_reg;

`ifndef SYNTHESIS
    // An error transaction is always a lone, final one with no position.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && rank_error) |-> (last && (symbol_position == '0)))
    else $error("error result without last or with a position");

    // While digits are extracted, the count stays within the symbol list.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kpu_pkg::KPU_DIGIT) |->
        ((count_reg != '0)
         && (count_reg <= kpu_pkg::LEN_W'(kpu_pkg::MAX_LENGTH))))
    else $error("remaining count out of range");

    // The digit never reaches past the remaining symbols.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kpu_pkg::KPU_DIGIT) |-> ({1'b0, digit_reg} < count_reg))
    else $error("digit beyond remaining symbols");

    // A result loaded by the digit stage removes exactly one symbol.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == kpu_pkg::KPU_DIGIT) && !step && slot_free) |=>
        (count_reg == $past(count_reg) - 5'd1))
    else $error("count not decremented on emit");
`endif

endmodule

### dv/tb_kth_permutation_unrank_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kth_permutation_unrank_unit: self-checking bench for the unranking unit
// A directed table and then random requests are sent while both sides stall
// at random. The bench unranks every accepted request itself and compares
// each result transaction, field by field, with the oldest pending position.
// ----------------------------------------------------------------------------
module tb_kth_permutation_unrank_unit;

    localparam int RANDOM_ITEMS = 200;
    localparam int QUIET_ITEMS  = 30;
    localparam int DRAIN_CYCLES = 160;
    localparam int MAX_REPORTS  = 10;

    // How the expected positions of a table row are produced.
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_ERROR,
        ROW_ASCENDING,
        ROW_DESCENDING
    } row_kind_t;

    typedef struct {
        kpu_pkg::len_t  length;
        kpu_pkg::rank_t rank;
        row_kind_t      kind;
    } stim_row_t;

    typedef struct {
        kpu_pkg::sym_t position;
        logic          last;
        logic          error;
    } position_t;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_ready;
    kpu_pkg::len_t  length;
    kpu_pkg::rank_t rank;
    logic           res_valid;
    logic           res_ready;
    kpu_pkg::sym_t  symbol_position;
    logic           last;
    logic           rank_error;

    logic  quiet_phase;
    int    failure_count = 0;

    position_t expected_positions[$];

    // Directed requests: extremes of both fields, every rejection reason,
    // single-symbol requests and a few ordinary ranks.
    stim_row_t directed_rows [0:20] = '{
        '{5'd1,  45'd0,                ROW_ASCENDING},
        '{5'd1,  45'd1,                ROW_ERROR},
        '{5'd0,  45'd0,                ROW_ERROR},
        '{5'd17, 45'd0,                ROW_ERROR},
        '{5'd31, 45'h1FFF_FFFF_FFFF,   ROW_ERROR},
        '{5'd16, 45'd0,                ROW_ASCENDING},
        '{5'd16, 45'd20922789887999,   ROW_DESCENDING},
        '{5'd16, 45'd20922789888000,   ROW_ERROR},
        '{5'd16, 45'h1FFF_FFFF_FFFF,   ROW_ERROR},
        '{5'd2,  45'd1,                ROW_DESCENDING},
        '{5'd3,  45'd3,                ROW_PREDICT},
        '{5'd4,  45'd23,               ROW_DESCENDING},
        '{5'd4,  45'd24,               ROW_ERROR},
        '{5'd5,  45'd60,               ROW_PREDICT},
        '{5'd8,  45'd12345,            ROW_PREDICT},
        '{5'd12, 45'd123456789,        ROW_PREDICT},
        '{5'd16, 45'd17592186044416,   ROW_PREDICT},
        '{5'd15, 45'd1307674367999,    ROW_DESCENDING},
        '{5'd10, 45'd0,                ROW_ASCENDING},
        '{5'd7,  45'd5039,             ROW_DESCENDING},
        '{5'd16, 45'd10461394944000,   ROW_PREDICT}
    };

    kth_permutation_unrank_unit uut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .length          (length),
        .rank            (rank),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .symbol_position (symbol_position),
        .last            (last),
        .rank_error      (rank_error)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit, far above the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic longint unsigned factorial_of(input int n);
        longint unsigned f;
        f = 1;
        for (int i = 2; i <= n; i++)
            f *= longint'(i);
        return f;
    endfunction

    function automatic longint unsigned random64();
        return {$urandom, $urandom};
    endfunction

    function automatic void push_position(input kpu_pkg::sym_t pos, input logic lst,
                                          input logic err);
        position_t item;
        item.position = pos;
        item.last     = lst;
        item.error    = err;
        expected_positions = {expected_positions, item};
    endfunction

    // Factorial number system: each digit picks an entry of the shrinking
    // list of unused positions.
    function automatic void unrank_permutation(input kpu_pkg::len_t n,
                                               input kpu_pkg::rank_t r);
        kpu_pkg::sym_t   pool [kpu_pkg::MAX_LENGTH];
        int              count;
        int              digit;
        longint unsigned remainder;
        longint unsigned weight;
        if (n == 0 || n > kpu_pkg::MAX_LENGTH || r >= factorial_of(n))
        begin
            push_position('0, 1'b1, 1'b1);
            return;
        end
        for (int i = 0; i < kpu_pkg::MAX_LENGTH; i++)
            pool[i] = kpu_pkg::sym_t'(i + 1);
        remainder = r;
        count     = n;
        while (count > 0)
        begin
            weight    = factorial_of(count - 1);
            digit     = int'(remainder / weight);
            push_position(pool[digit], count == 1, 1'b0);
            remainder = remainder - longint'(digit) * weight;
            for (int j = digit; j + 1 < count; j++)
                pool[j] = pool[j + 1];
            count--;
        end
    endfunction

    // Table rows whose answer is obvious carry it directly.
    function automatic void predict_row_positions(input stim_row_t row);
        case (row.kind)
            ROW_ERROR:
                push_position('0, 1'b1, 1'b1);
            ROW_ASCENDING:
                for (int i = 1; i <= row.length; i++)
                    push_position(kpu_pkg::sym_t'(i), i == row.length, 1'b0);
            ROW_DESCENDING:
                for (int i = row.length; i >= 1; i--)
                    push_position(kpu_pkg::sym_t'(i), i == 1, 1'b0);
            default:
                unrank_permutation(row.length, row.rank);
        endcase
    endfunction

    // Mostly short requests, since the cost of a request grows with its length.
    function automatic kpu_pkg::len_t draw_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return kpu_pkg::len_t'($urandom_range(1, 6));
        else if (pick < 90)
            return kpu_pkg::len_t'($urandom_range(7, 12));
        else
            return kpu_pkg::len_t'($urandom_range(13, kpu_pkg::MAX_LENGTH));
    endfunction

    // Most requests are legal; the rest are rejected for rank or length.
    function automatic void draw_request(output kpu_pkg::len_t n,
                                         output kpu_pkg::rank_t r);
        int              pick;
        longint unsigned bound;
        longint unsigned span;
        pick  = $urandom_range(0, 99);
        n     = draw_length();
        bound = factorial_of(n);
        if (pick < 65)
        begin
            if ($urandom_range(0, 9) == 0)
                r = ($urandom_range(0, 1) == 1) ? kpu_pkg::rank_t'(bound - 1) : '0;
            else
                r = kpu_pkg::rank_t'(random64() % bound);
        end
        else if (pick < 80)
        begin
            span = (64'd1 << kpu_pkg::RANK_W) - bound;
            r    = kpu_pkg::rank_t'(bound + random64() % span);
        end
        else if (pick < 90)
        begin
            r = kpu_pkg::rank_t'(bound);
        end
        else
        begin
            n = ($urandom_range(0, 3) == 0) ? '0 :
                kpu_pkg::len_t'($urandom_range(kpu_pkg::MAX_LENGTH + 1, 31));
            r = kpu_pkg::rank_t'(random64());
        end
    endfunction

    // Present one request and return at the edge that accepts it.
    task automatic send_request(input kpu_pkg::len_t n, input kpu_pkg::rank_t r);
        req_valid <= 1'b1;
        length    <= n;
        rank      <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic sender_gap(input int pct);
        int cycles;
        if ($urandom_range(0, 99) < pct)
        begin
            cycles = $urandom_range(1, 9);
            req_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Hold off new requests until every pending position has come back.
    task automatic wait_for_drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (expected_positions.size() != 0)
            @(posedge clk);
    endtask

    function automatic void note_failure(input string msg);
        failure_count++;
        if (failure_count <= MAX_REPORTS)
            $display("[%0t] %s", $realtime, msg);
    endfunction

    // Result side stalls in bursts; the burst rate changes now and then so
    // that there are also stretches without stalls.
    initial
    begin
        int stall_left;
        int stall_pct;
        res_ready <= 1'b0;
        stall_left = 0;
        stall_pct  = 20;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 63) == 0)
                stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 35);
            if (quiet_phase)
            begin
                res_ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                res_ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(1, 9) - 1;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= 1'b1;
            end
        end
    end

    // Compare each result transaction with the oldest pending position.
    always @(posedge clk)
    begin
        position_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_positions.size() == 0)
            begin
                note_failure($sformatf("unexpected result: pos %0d last %0b err %0b",
                                       symbol_position, last, rank_error));
            end
            else
            begin
                want = expected_positions.pop_front();
                if (symbol_position !== want.position || last !== want.last ||
                    rank_error !== want.error)
                    note_failure($sformatf(
                        "mismatch: expected pos %0d last %0b err %0b, got pos %0d last %0b err %0b",
                        want.position, want.last, want.error,
                        symbol_position, last, rank_error));
            end
        end
    end

    // Main sequence: reset, directed table, random requests, drain.
    initial
    begin
        kpu_pkg::len_t  n;
        kpu_pkg::rank_t r;
        int             gap_pct;
        rst_n       <= 1'b0;
        req_valid   <= 1'b0;
        length      <= '0;
        rank        <= '0;
        quiet_phase <= 1'b0;
        gap_pct     = 25;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].length, directed_rows[i].rank);
            predict_row_positions(directed_rows[i]);
            sender_gap(25);
        end
        wait_for_drain();

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % 20 == 0)
                gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(15, 40);
            if (k == RANDOM_ITEMS / 2)
                wait_for_drain();
            if (k >= RANDOM_ITEMS - QUIET_ITEMS)
            begin
                quiet_phase <= 1'b1;
                gap_pct = 0;
            end
            draw_request(n, r);
            send_request(n, r);
            unrank_permutation(n, r);
            sender_gap(gap_pct);
        end
        req_valid <= 1'b0;

        while (expected_positions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failure_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
hdl/kpu_pkg.sv
hdl/kth_permutation_unrank_unit.sv
dv/tb_kth_permutation_unrank_unit.sv
